[hw/rtl/fbb_pkg.sv]
// Shared constants, codes and types of the monochrome frame-store blitter.
package fbb_pkg;

    localparam int MAX_WIDTH   = 128;
    localparam int MAX_HEIGHT  = 64;
    localparam int STORE_BYTES = (MAX_WIDTH * MAX_HEIGHT) / 8;
    localparam int ADDR_W      = $clog2(STORE_BYTES);

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [7:0] WIDTH_RST  = 8'd128;
    localparam logic [6:0] HEIGHT_RST = 7'd64;

    // stream widths
    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 16;

    // item operations
    typedef enum logic [2:0] {
        FN_SET    = 3'd0,
        FN_CLR    = 3'd1,
        FN_TGL    = 3'd2,
        FN_GET    = 3'd3,
        FN_BLIT   = 3'd4,
        FN_RDB    = 3'd5,
        FN_CLRALL = 3'd6
    } t_func;

    // store access kinds
    typedef enum logic [2:0] {
        OP_SET,
        OP_CLR,
        OP_TGL,
        OP_GET,
        OP_RDB,
        OP_ZERO
    } t_op_kind;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [7:0] width;
        logic [6:0] height;
    } t_cfg;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [3:0] scale_x;
        logic [7:0] src_byte;
        logic [4:0] byte_index;
        logic [7:0] row_bits;
        logic [9:0] address;
    } t_item;

    // one store access issued by the sequencer
    typedef struct packed {
        logic              vld;
        t_op_kind          kind;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        bit_idx;
    } t_pix_op;

    // store write port
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr;

    // read result, also the finished item's result
    typedef struct packed {
        logic       vld;
        logic       pv;
        logic [7:0] bv;
    } t_rd_res;

endpackage

[hw/rtl/fbb_store.sv]
// Frame store: one write port, one read port with registered read data.
module fbb_store (
    input  logic                      i_clk,
    input  fbb_pkg::t_wr              i_wr,
    input  logic [fbb_pkg::ADDR_W-1:0] i_raddr,
    output logic [7:0]                o_rdata
);
    import fbb_pkg::*;

    logic [7:0] r_mem [STORE_BYTES];
    logic [7:0] r_rdata;

    // write and read the array
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/fbb_rmw.sv]
// Read-modify-write stage: merges read data with the last write and updates the byte.
module fbb_rmw (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fbb_pkg::t_pix_op  i_op,
    input  logic [7:0]        i_rdata,
    output fbb_pkg::t_wr      o_wr,
    output fbb_pkg::t_rd_res  o_res
);
    import fbb_pkg::*;

    t_pix_op    r_op;
    t_wr        r_last;
    logic [7:0] base;
    logic [7:0] mask;

    // hold the access whose read is in flight and the write just done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op   <= '0;
            r_last <= '0;
        end else begin
            r_op   <= i_op;
            r_last <= o_wr;
        end
    end

    // the write of the previous cycle is not yet in the read data
    assign base = (r_last.we && (r_last.addr == r_op.addr)) ? r_last.data : i_rdata;
    assign mask = 8'b1 << r_op.bit_idx;

    // modify the byte and drive the write port or the read result
    always_comb begin
        o_wr      = '0;
        o_wr.addr = r_op.addr;
        o_res     = '0;
        if (r_op.vld) begin
            case (r_op.kind)
                OP_SET: begin
                    o_wr.we   = 1'b1;
                    o_wr.data = base | mask;
                end
                OP_CLR: begin
                    o_wr.we   = 1'b1;
                    o_wr.data = base & ~mask;
                end
                OP_TGL: begin
                    o_wr.we   = 1'b1;
                    o_wr.data = base ^ mask;
                end
                OP_ZERO: begin
                    o_wr.we   = 1'b1;
                    o_wr.data = 8'd0;
                end
                OP_GET: begin
                    o_res.vld = 1'b1;
                    o_res.pv  = base[r_op.bit_idx];
                end
                OP_RDB: begin
                    o_res.vld = 1'b1;
                    o_res.bv  = base;
                end
                default: ;
            endcase
        end
    end

    a_no_write_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_wr.we && o_res.vld))
        else $error("store write and read result in the same cycle");

    a_forward_last_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_op.vld && $past(o_wr.we) && (r_op.addr == $past(o_wr.addr)))
            |-> (base == $past(o_wr.data)))
        else $error("back-to-back access to one byte missed the last write");

endmodule

[hw/rtl/fbb_seq.sv]
// Sequencer: takes items, walks pixels of a blit, sweeps clears, collects results.
module fbb_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fbb_pkg::t_cfg     i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fbb_pkg::t_item    i_item,
    input  fbb_pkg::t_rd_res  i_res,
    output fbb_pkg::t_pix_op  o_op,
    output fbb_pkg::t_rd_res  o_done,
    input  logic              i_out_free
);
    import fbb_pkg::*;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_clr;
    logic              r_init;

    t_func             r_func;
    logic [7:0]        r_x;
    logic [7:0]        r_y;
    logic [3:0]        r_scale;
    logic [7:0]        r_src;
    logic [4:0]        r_bidx;
    logic [7:0]        r_rbits;
    logic [ADDR_W-1:0] r_addr;
    logic [3:0]        r_j;
    logic [3:0]        r_s;
    logic              r_pv;
    logic [7:0]        r_bv;

    logic              accept;
    logic [4:0]        blit_prod;
    logic [7:0]        x_start;
    logic              base_in;
    logic [12:0]       row_base;
    logic [12:0]       row_sum;
    logic [ADDR_W-1:0] pix_addr;
    logic              x_in;
    logic              y_in;
    logic [7:0]        bit_pos;
    logic              row_end;
    logic              last_s;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // first pixel of this source byte: base x plus byte_index*8*scale, mod 256
    // (only byte_index*scale mod 32 survives the shift by three)
    assign blit_prod = i_item.byte_index * {1'b0, i_item.scale_x};
    assign x_start   = i_item.pos_x + {blit_prod, 3'b000};
    assign base_in   = (i_item.pos_x < i_cfg.width) && (i_item.pos_y < {1'b0, i_cfg.height});

    // pixel address from row and stride
    assign row_base = {5'd0, r_y} * {8'd0, i_cfg.width[7:3]};
    assign row_sum  = row_base + {8'd0, r_x[7:3]};
    assign pix_addr = row_sum[ADDR_W-1:0];
    assign x_in     = r_x < i_cfg.width;
    assign y_in     = r_y < {1'b0, i_cfg.height};

    // blit bit position and end of the drawn bits
    assign bit_pos = {r_bidx, r_j[2:0]};
    assign row_end = r_j[3] || (bit_pos >= r_rbits);
    assign last_s  = (r_s == (r_scale - 4'd1));

    // state register and sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_init  <= 1'b1;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
                if (&r_clr) begin
                    r_init <= 1'b0;
                end
            end
        end
    end

    // capture item fields, advance blit counters, collect read results
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= t_func'(i_item.func);
            r_x     <= (t_func'(i_item.func) == FN_BLIT) ? x_start : i_item.pos_x;
            r_y     <= i_item.pos_y;
            r_scale <= i_item.scale_x;
            r_src   <= i_item.src_byte;
            r_bidx  <= i_item.byte_index;
            r_rbits <= i_item.row_bits;
            r_addr  <= i_item.address[ADDR_W-1:0];
            r_j     <= 4'd0;
            r_s     <= 4'd0;
            r_pv    <= 1'b0;
            r_bv    <= 8'd0;
        end else begin
            if ((r_state == S_ISSUE) && (r_func == FN_BLIT) && !row_end) begin
                r_x <= r_x + 8'd1;
                if (last_s) begin
                    r_s <= 4'd0;
                    r_j <= r_j + 4'd1;
                end else begin
                    r_s <= r_s + 4'd1;
                end
            end
            if (i_res.vld) begin
                r_pv <= i_res.pv;
                r_bv <= i_res.bv;
            end
        end
    end

    // next state and store accesses
    always_comb begin
        n_state = r_state;
        o_op    = '0;
        o_done  = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_op.vld  = 1'b1;
                o_op.kind = OP_ZERO;
                o_op.addr = r_clr;
                if (&r_clr) begin
                    n_state = r_init ? S_IDLE : S_WAIT;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (t_func'(i_item.func)) inside
                        FN_SET, FN_CLR, FN_TGL, FN_GET, FN_RDB: n_state = S_ISSUE;
                        FN_BLIT: begin
                            n_state = (base_in && (i_item.scale_x != 4'd0)) ? S_ISSUE : S_DONE;
                        end
                        FN_CLRALL: n_state = S_CLEAR;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_ISSUE: begin
                o_op.addr    = pix_addr;
                o_op.bit_idx = r_x[2:0];
                if (r_func == FN_BLIT) begin
                    if (row_end) begin
                        n_state = S_WAIT;
                    end else begin
                        o_op.vld  = x_in;
                        o_op.kind = r_src[r_j[2:0]] ? OP_SET : OP_CLR;
                    end
                end else begin
                    n_state = S_WAIT;
                    case (r_func)
                        FN_SET: begin
                            o_op.vld  = x_in && y_in;
                            o_op.kind = OP_SET;
                        end
                        FN_CLR: begin
                            o_op.vld  = x_in && y_in;
                            o_op.kind = OP_CLR;
                        end
                        FN_TGL: begin
                            o_op.vld  = x_in && y_in;
                            o_op.kind = OP_TGL;
                        end
                        FN_GET: begin
                            o_op.vld  = x_in && y_in;
                            o_op.kind = OP_GET;
                        end
                        FN_RDB: begin
                            o_op.vld  = 1'b1;
                            o_op.kind = OP_RDB;
                            o_op.addr = r_addr;
                        end
                        default: ;
                    endcase
                end
            end
            S_WAIT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                o_done.vld = 1'b1;
                o_done.pv  = r_pv;
                o_done.bv  = r_bv;
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_idle_no_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_op.vld)
        else $error("store access issued while idle");

    a_sweep_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CLEAR) && $past(r_state == S_CLEAR) && $past(i_rst_n))
            |-> (r_clr == $past(r_clr) + 1'b1))
        else $error("clear sweep skipped an entry");

    a_blit_nonzero_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ISSUE) && (r_func == FN_BLIT)) |-> (r_scale != 4'd0))
        else $error("blit running with zero scale");

endmodule

[hw/rtl/mono_framebuffer_blitter.sv]
// Top level of the monochrome frame-store blitter: ports, registers, output stage.
//
// Input channel (i_s_*): one word per item, operation code in tuser, operands in
// tdata. Output channel (o_m_*): exactly one word per item, pixel value and store byte.
// Configuration: i_cfg_we writes display_width (index 0) or display_height (index 1)
// at the clock edge; write only while no item is in flight.
// Work per item: set, clear, toggle, get pixel and read byte make at most one store access;
// a blit byte steps through its pixel count (drawn bits x scale_x, up to 120,
// clipped pixels included), one pixel per cycle through the store's
// read-modify-write path; a blit with base out of range or zero scale and the
// unused code skip the store; clear all sweeps the store, one store byte per cycle.
// One item is in work at a time: the next word is taken the cycle after the
// result has moved into the output register.
// Reset: synchronous, active low; the store's 1024 bytes are then swept to zero
// with o_s_tready low, and the registers return to 128 x 64.
// Stall: a result waits in the output register while i_m_tready is low; the
// block can take and finish the next item meanwhile, then waits to deliver it.
module mono_framebuffer_blitter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration port
    input  logic                              i_cfg_we,
    input  logic [fbb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [7:0]                        i_cfg_data,
    // input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // pos_x, pos_y, scale_x, src_byte, byte_index, row_bits, address, zero pad
    input  logic [fbb_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // func
    input  logic [fbb_pkg::IN_USER_W-1:0]     i_s_tuser,
    // output stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // pixel_value, byte_value, zero pad
    output logic [fbb_pkg::OUT_DATA_W-1:0]    o_m_tdata
);
    import fbb_pkg::*;

    t_cfg                  r_cfg;
    t_item                 item;
    t_pix_op               op;
    t_wr                   wr;
    t_rd_res               res;
    t_rd_res               done;
    logic [7:0]            rdata;
    logic                  out_free;
    logic                  r_tvalid;
    logic [OUT_DATA_W-1:0] r_tdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= WIDTH_RST;
            r_cfg.height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIDTH:  r_cfg.width  <= i_cfg_data;
                CFG_HEIGHT: r_cfg.height <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // unpack the input word
    always_comb begin
        item.func       = i_s_tuser;
        item.pos_x      = i_s_tdata[7:0];
        item.pos_y      = i_s_tdata[15:8];
        item.scale_x    = i_s_tdata[19:16];
        item.src_byte   = i_s_tdata[27:20];
        item.byte_index = i_s_tdata[32:28];
        item.row_bits   = i_s_tdata[40:33];
        item.address    = i_s_tdata[50:41];
    end

    fbb_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_item     (item),
        .i_res      (res),
        .o_op       (op),
        .o_done     (done),
        .i_out_free (out_free)
    );

    fbb_store u_store (
        .i_clk   (i_clk),
        .i_wr    (wr),
        .i_raddr (op.addr),
        .o_rdata (rdata)
    );

    fbb_rmw u_rmw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op),
        .i_rdata (rdata),
        .o_wr    (wr),
        .o_res   (res)
    );

    // output register: load a finished result when empty or being drained
    assign out_free = !r_tvalid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
        end else if (done.vld && out_free) begin
            r_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done.vld && out_free) begin
            r_tdata <= {{(OUT_DATA_W - 9){1'b0}}, done.bv, done.pv};
        end
    end

    assign o_m_tvalid = r_tvalid;
    assign o_m_tdata  = r_tdata;

endmodule
